@@ src/dshot_pkg.sv @@
// ----------------------------------------------------------------------------
// dshot_pkg
// Shared constants and helper functions for the DShot600 frame encoder.
// ----------------------------------------------------------------------------
package dshot_pkg;

  localparam int FRAME_BITS = 16;
  localparam int CNT_W      = $clog2(FRAME_BITS);

  localparam int CH_W       = 2;
  localparam int THR_W      = 16;
  localparam int TICK_W     = 15;
  localparam int DUTY_W     = 10;
  localparam int CFG_IDX_W  = 3;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic [THR_W-1:0]  THR_MIN         = THR_W'(1000);
  localparam logic [THR_W-1:0]  THR_MAX         = THR_W'(2000);
  localparam logic [11:0]       DSHOT_OFFSET    = 12'd48;
  localparam logic [11:0]       DSHOT_VALUE_MAX = 12'd2047;

  localparam logic [TICK_W-1:0] ZERO_HIGH_RST = TICK_W'(24);
  localparam logic [TICK_W-1:0] ZERO_LOW_RST  = TICK_W'(50);
  localparam logic [TICK_W-1:0] ONE_HIGH_RST  = TICK_W'(50);
  localparam logic [TICK_W-1:0] ONE_LOW_RST   = TICK_W'(25);

  localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW_TICKS   = 3'd4;

  localparam logic MODE_PWM   = 1'b0;
  localparam logic MODE_DSHOT = 1'b1;

  function automatic logic [THR_W-1:0] clamp_throttle(input logic [THR_W-1:0] t);
    logic [THR_W-1:0] r;
    r = t;
    if (t < THR_MIN) r = THR_MIN;
    if (t > THR_MAX) r = THR_MAX;
    return r;
  endfunction

  function automatic logic [FRAME_BITS-1:0] build_frame(input logic [THR_W-1:0] t);
    logic [11:0] v;
    logic [11:0] word;
    logic [3:0]  csum;
    v = {t[10:0] - THR_MIN[10:0], 1'b0} + DSHOT_OFFSET;
    if (v > DSHOT_VALUE_MAX) v = DSHOT_VALUE_MAX;
    word = {v[10:0], 1'b0};
    csum = word[3:0] ^ word[7:4] ^ word[11:8];
    return {word, csum};
  endfunction

endpackage

@@ src/dshot600_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// dshot600_frame_encoder
// Pipeline: input register, serializer register, output register.
// DShot mode: one pulse per frame bit, one pulse per cycle from the frame
// shift register unless m_tready stalls it; PWM mode: one result per command.
// Reset: synchronous; clears all valid flags, restores register defaults.
// ----------------------------------------------------------------------------
module dshot600_frame_encoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [1:0] motor_channel, [17:2] throttle_raw, [23:18] zero
  input  logic [dshot_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [1:0] out_channel, [2] frame_bit, [17:3] high_ticks, [32:18] low_ticks,
  // [42:33] pwm_duty, [47:43] zero
  output logic [dshot_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [dshot_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dshot_pkg::TICK_W-1:0]        cfg_data
);
  import dshot_pkg::*;

  logic              protocol_mode;
  logic [TICK_W-1:0] zero_high_ticks;
  logic [TICK_W-1:0] zero_low_ticks;
  logic [TICK_W-1:0] one_high_ticks;
  logic [TICK_W-1:0] one_low_ticks;

  logic             in_valid;
  logic [CH_W-1:0]  in_ch;
  logic [THR_W-1:0] in_thr;

  logic                  ser_valid;
  logic                  ser_mode;
  logic [CH_W-1:0]       ser_ch;
  logic [FRAME_BITS-1:0] ser_frame;
  logic [DUTY_W-1:0]     ser_duty;
  logic [CNT_W-1:0]      ser_cnt;

  logic                  out_load;
  logic                  ser_last;
  logic                  ser_done;
  logic                  in_load;
  logic [THR_W-1:0]      thr_clamped;
  logic [THR_W-1:0]      duty_full;
  logic                  cur_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_mode   <= MODE_DSHOT;
      zero_high_ticks <= ZERO_HIGH_RST;
      zero_low_ticks  <= ZERO_LOW_RST;
      one_high_ticks  <= ONE_HIGH_RST;
      one_low_ticks   <= ONE_LOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROTOCOL_MODE:   protocol_mode   <= cfg_data[0];
        REG_ZERO_HIGH_TICKS: zero_high_ticks <= cfg_data;
        REG_ZERO_LOW_TICKS:  zero_low_ticks  <= cfg_data;
        REG_ONE_HIGH_TICKS:  one_high_ticks  <= cfg_data;
        REG_ONE_LOW_TICKS:   one_low_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_load    = !m_tvalid || m_tready;
  assign ser_last    = (ser_mode == MODE_PWM) || (ser_cnt == CNT_W'(FRAME_BITS - 1));
  assign ser_done    = ser_valid && out_load && ser_last;
  assign in_load     = in_valid && (!ser_valid || ser_done);
  assign s_tready    = !in_valid || in_load;
  assign thr_clamped = clamp_throttle(in_thr);
  assign duty_full   = thr_clamped - THR_MIN;
  assign cur_bit     = ser_frame[FRAME_BITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_ch  <= s_tdata[CH_W-1:0];
      in_thr <= s_tdata[CH_W +: THR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_cnt   <= '0;
    end else if (in_load) begin
      ser_valid <= 1'b1;
      ser_cnt   <= '0;
    end else if (ser_done) begin
      ser_valid <= 1'b0;
    end else if (ser_valid && out_load) begin
      ser_cnt <= ser_cnt + CNT_W'(1);
    end
    if (in_load) begin
      ser_mode  <= protocol_mode;
      ser_ch    <= in_ch;
      ser_frame <= build_frame(thr_clamped);
      ser_duty  <= duty_full[DUTY_W-1:0];
    end else if (ser_valid && out_load) begin
      ser_frame <= {ser_frame[FRAME_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= ser_valid;
    end
    if (out_load && ser_valid) begin
      m_tlast <= ser_last;
      if (ser_mode == MODE_PWM) begin
        m_tdata <= {5'b0, ser_duty, {TICK_W{1'b0}}, {TICK_W{1'b0}}, 1'b0, ser_ch};
      end else begin
        m_tdata <= {5'b0, {DUTY_W{1'b0}},
                    cur_bit ? one_low_ticks : zero_low_ticks,
                    cur_bit ? one_high_ticks : zero_high_ticks,
                    cur_bit, ser_ch};
      end
    end
  end

  a_pwm_single : assert property (@(posedge clk) disable iff (rst)
    ser_valid && (ser_mode == MODE_PWM) |-> ser_cnt == '0)
    else $error("PWM command advanced the bit counter");

  a_load_start : assert property (@(posedge clk) disable iff (rst)
    in_load |=> ser_valid && (ser_cnt == '0))
    else $error("serializer did not start a new command");

  a_pwm_fields : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[42:33] != '0) |-> (m_tdata[32:2] == '0) && m_tlast)
    else $error("PWM result carries pulse fields");

endmodule
